[sv/lrupr_pkg.sv]
`timescale 1ns / 1ps

package lrupr_pkg;

   localparam int FRAMES      = 8;
   localparam int PAGE_BITS   = 16;
   localparam int IN_BITS     = 16;
   localparam int FRAME_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int STORE_BITS  = (PAGE_BITS < IN_BITS) ? PAGE_BITS : IN_BITS;
   localparam int INDEX_BITS  = 3;
   localparam int COUNT_BITS  = 32;

   typedef logic [STORE_BITS-1:0] page_type;
   typedef logic [FRAME_BITS-1:0] frame_type;

   // one recency slot: the frame at this position and what it holds
   typedef struct packed {
      logic      valid;
      frame_type frame;
      page_type  page;
   } entry_type;

endpackage

[sv/lrupr_if.sv]
`timescale 1ns / 1ps

interface lrupr_req_if;
   logic                        valid;
   logic                        ready;
   logic [lrupr_pkg::IN_BITS-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic [lrupr_pkg::INDEX_BITS-1:0]    frame_index;
   logic                                evicted_valid;
   logic [lrupr_pkg::IN_BITS-1:0]       evicted_page;
   logic [lrupr_pkg::COUNT_BITS-1:0]    faults_so_far;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output faults_so_far, input ready);
   modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                   input evicted_page, input faults_so_far, output ready);
endinterface

[sv/lrupr_cell.sv]
`timescale 1ns / 1ps

module lrupr_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  lrupr_pkg::frame_type init_frame,
   input  logic                 step,
   input  lrupr_pkg::page_type  page,
   input  lrupr_pkg::entry_type up_entry,
   input  logic                 hit_before,
   output lrupr_pkg::entry_type entry,
   output logic                 match,
   output logic                 hit_after
);

   lrupr_pkg::entry_type ent_ff, ent_in;

   assign match     = ent_ff.valid && (ent_ff.page == page);
   assign hit_after = hit_before | match;
   assign entry     = ent_ff;

   // on an accepted request, shift in from the more recent neighbor unless the hit lies above us
   always_comb begin
      ent_in = ent_ff;
      if (step && !hit_before) begin
         ent_in = up_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
         ent_ff.frame <= init_frame;
         ent_ff.page  <= '0;
      end else begin
         ent_ff <= ent_in;
      end
   end

endmodule

[sv/lru_page_replacement.sv]
`timescale 1ns / 1ps

// channel  | dir | beat contents
// req_bus  | in  | page_number
// rsp_bus  | out | hit, frame_index, evicted_valid, evicted_page, faults_so_far
//
// One request per cycle while the response is taken; its response appears in the cycle after acceptance.
// All frames are compared in parallel and the row of recency cells shifts
// in the same cycle, so the compare and shift across the cell row set the cycle.
// Reset clears valid marks, restores the initial recency order and the fault count.
// A stalled response holds in the output register; a new request is taken as it leaves.

module lru_page_replacement (
   input  logic         clock,
   input  logic         reset,
   lrupr_req_if.sink    req_bus,
   lrupr_rsp_if.source  rsp_bus
);

   localparam int N = lrupr_pkg::FRAMES;

   lrupr_pkg::page_type  page;
   lrupr_pkg::entry_type entries   [N];
   lrupr_pkg::entry_type up_entries[N];
   logic [N-1:0]         match_bits;
   logic [N:0]           hit_chain;
   lrupr_pkg::frame_type hit_frame;
   lrupr_pkg::frame_type used_frame;
   lrupr_pkg::entry_type tail;
   logic                 found;
   logic                 step;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  hit_ff;
   logic [lrupr_pkg::INDEX_BITS-1:0]      index_ff;
   logic                                  ev_valid_ff;
   logic [lrupr_pkg::IN_BITS-1:0]         ev_page_ff;
   logic [lrupr_pkg::COUNT_BITS-1:0]      fault_ff, fault_in;

   assign page            = lrupr_pkg::STORE_BITS'(req_bus.page_number);
   assign req_bus.ready   = !rsp_valid_ff || rsp_bus.ready;
   assign step            = req_bus.valid && req_bus.ready;
   assign hit_chain[0]    = 1'b0;
   assign found           = hit_chain[N];
   assign tail            = entries[N-1];

   always_comb begin
      hit_frame = '0;
      for (int p = 0; p < N; p++) begin
         if (match_bits[p]) begin
            hit_frame = hit_frame | entries[p].frame;
         end
      end
   end

   // a miss takes the least recent slot, which is also the next empty frame while filling
   assign used_frame = found ? hit_frame : tail.frame;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign up_entries[g] = '{valid: 1'b1, frame: used_frame, page: page};
         end else begin : g_body
            assign up_entries[g] = entries[g-1];
         end

         lrupr_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .init_frame (lrupr_pkg::FRAME_BITS'(N - 1 - g)),
            .step       (step),
            .page       (page),
            .up_entry   (up_entries[g]),
            .hit_before (hit_chain[g]),
            .entry      (entries[g]),
            .match      (match_bits[g]),
            .hit_after  (hit_chain[g+1])
         );
      end
   endgenerate

   always_comb begin
      fault_in = fault_ff;
      if (step && !found && (fault_ff != {lrupr_pkg::COUNT_BITS{1'b1}})) begin
         fault_in = fault_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fault_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         fault_ff     <= fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         hit_ff      <= found;
         index_ff    <= lrupr_pkg::INDEX_BITS'(used_frame);
         ev_valid_ff <= !found && tail.valid;
         ev_page_ff  <= (!found && tail.valid) ? lrupr_pkg::IN_BITS'(tail.page) : '0;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = hit_ff;
   assign rsp_bus.frame_index   = index_ff;
   assign rsp_bus.evicted_valid = ev_valid_ff;
   assign rsp_bus.evicted_page  = ev_page_ff;
   assign rsp_bus.faults_so_far = fault_ff;

endmodule
